// ===== design/dtfhf_pkg.sv =====
// Shared types and constants for the depth temporal filter with hole fill.
// Used by every module of the block; depends on nothing else.
package dtfhf_pkg;

  localparam int unsigned GAP_LIMIT_MAX  = 63;
  localparam int unsigned WEIGHT_FULL    = 256;
  localparam int unsigned BLEND_RESET    = 192;
  localparam int unsigned GAP_RESET      = 16;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  typedef enum logic [0:0] {
    CFG_BLEND_WEIGHT = 1'b0,
    CFG_GAP_LIMIT    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] raw_depth;
    logic [15:0] history_depth;
    logic        row_end;
  } in_t;

  typedef struct packed {
    logic [15:0] filled_depth;
    logic [15:0] new_history;
    logic        last_of_run;
    logic        row_done;
  } out_t;

  // Clamped configuration as the datapath sees it.
  typedef struct packed {
    logic [8:0] weight;
    logic [5:0] limit;
  } cfg_t;

  // One queued job: a run of holes (interpolated or zero) followed by the pixel.
  typedef struct packed {
    logic        interp;
    logic [5:0]  holes;
    logic [15:0] left;
    logic [15:0] value;
    logic        row_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic take;
    logic busy;
  } back_stat_t;

endpackage

// ===== design/dtfhf_front.sv =====
// Front end: accepts pixels, does the temporal blend and tracks the zero runs.
// Pushes one job per result-producing pixel into the queue; uses dtfhf_pkg.
module dtfhf_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dtfhf_pkg::cfg_t        cfg_i,
  input  logic                   in_valid_i,
  input  dtfhf_pkg::in_t         in_data_i,
  output logic                   in_stall_o,
  input  dtfhf_pkg::fifo_stat_t  fifo_i,
  output logic                   push_o,
  output dtfhf_pkg::cmd_t        cmd_o
);

  logic        s1_valid_q;
  logic [24:0] p_raw_q, p_hist_q;
  logic [15:0] raw_q, hist_q;
  logic        row_end_q;

  logic [15:0] left_q, left_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        unf_q, unf_d;

  logic [24:0] sum;
  logic [15:0] v;
  logic        emit;
  logic        advance;
  logic        accept;

  assign accept = in_valid_i && !in_stall_o;

  // The two products are registered; the add and the run logic follow.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_raw_q   <= 25'(cfg_i.weight) * 25'(in_data_i.raw_depth);
      p_hist_q  <= 25'(9'(dtfhf_pkg::WEIGHT_FULL) - cfg_i.weight) *
                   25'(in_data_i.history_depth);
      raw_q     <= in_data_i.raw_depth;
      hist_q    <= in_data_i.history_depth;
      row_end_q <= in_data_i.row_end;
    end
  end

  assign sum = p_raw_q + p_hist_q;

  always_comb begin
    if (raw_q == 16'd0) begin
      v = hist_q;
    end else if (hist_q == 16'd0) begin
      v = raw_q;
    end else begin
      v = sum[23:8];
    end
  end

  always_comb begin
    emit          = 1'b1;
    left_d        = left_q;
    cnt_d         = cnt_q;
    unf_d         = unf_q;
    cmd_o.interp  = 1'b0;
    cmd_o.holes   = 6'd0;
    cmd_o.left    = left_q;
    cmd_o.value   = v;
    cmd_o.row_end = row_end_q;
    if (v != 16'd0) begin
      cmd_o.interp = 1'b1;
      cmd_o.holes  = cnt_q;
      left_d       = v;
      cnt_d        = 6'd0;
      unf_d        = 1'b0;
    end else if (left_q == 16'd0 || unf_q) begin
      cmd_o.holes = 6'd0;
    end else if (cnt_q < cfg_i.limit && !row_end_q) begin
      emit  = 1'b0;
      cnt_d = cnt_q + 6'd1;
    end else begin
      // The run is too long or hits the row end: flush it as zeros.
      cmd_o.holes = cnt_q;
      cnt_d       = 6'd0;
      if (!row_end_q) begin
        unf_d = 1'b1;
      end
    end
    if (row_end_q) begin
      left_d = 16'd0;
      cnt_d  = 6'd0;
      unf_d  = 1'b0;
    end
  end

  assign advance    = !emit || !fifo_i.full;
  assign in_stall_o = s1_valid_q && !advance;
  assign push_o     = s1_valid_q && emit && !fifo_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      left_q     <= 16'd0;
      cnt_q      <= 6'd0;
      unf_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !advance);
      if (s1_valid_q && advance) begin
        left_q <= left_d;
        cnt_q  <= cnt_d;
        unf_q  <= unf_d;
      end
    end
  end

endmodule

// ===== design/dtfhf_fifo.sv =====
// Short job queue between the front end and the back end.
// Holds dtfhf_pkg::cmd_t entries in registers; uses dtfhf_pkg.
module dtfhf_fifo #(
  parameter int unsigned DEPTH = dtfhf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dtfhf_pkg::cmd_t       data_i,
  input  logic                  pop_i,
  output dtfhf_pkg::cmd_t       data_o,
  output dtfhf_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dtfhf_pkg::cmd_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/dtfhf_back.sv =====
// Back end: expands queued jobs into output pixels, interpolating hole runs.
// One serial divide per gap gives the step; uses dtfhf_pkg.
module dtfhf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dtfhf_pkg::fifo_stat_t fifo_i,
  input  dtfhf_pkg::cmd_t       cmd_i,
  output dtfhf_pkg::back_stat_t stat_o,
  output logic                  out_valid_o,
  output dtfhf_pkg::out_t       out_data_o,
  input  logic                  out_stall_i
);

  localparam int unsigned DIV_STEPS = 16;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e          state_q;
  dtfhf_pkg::cmd_t cmd_q;
  logic [5:0]      holes_left_q;
  logic [3:0]      step_q;
  logic [15:0]     quot_q;
  logic [5:0]      rem_q;
  logic            neg_q;
  logic [17:0]     dq_q, q_q;
  logic [5:0]      dr_q, r_q;
  logic            out_valid_q;
  dtfhf_pkg::out_t out_q;

  logic       load, load_final, take;
  logic [6:0] trial;
  logic       ge;
  logic [6:0] rs;
  logic       wrap;

  assign load       = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign load_final = load && (holes_left_q == 6'd0);
  assign take       = !fifo_i.empty && ((state_q == ST_IDLE) || load_final);

  assign stat_o.take = take;
  assign stat_o.busy = (state_q != ST_IDLE);

  // Restoring divide of |right - left| by the run length, one bit a cycle.
  assign trial = {rem_q, quot_q[15]};
  assign ge    = trial >= {1'b0, cmd_q.holes};

  // Hole k+1 from hole k: the numerator grows by the step, tracked as
  // quotient and remainder so no divide is needed per pixel.
  assign rs   = {1'b0, r_q} + {1'b0, dr_q};
  assign wrap = rs >= {1'b0, cmd_q.holes};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      holes_left_q <= 6'd0;
      step_q       <= 4'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        holes_left_q <= cmd_i.holes;
        step_q       <= 4'd0;
        state_q      <= (cmd_i.interp && cmd_i.holes != 6'd0) ? ST_DIV : ST_EMIT;
      end else begin
        case (state_q)
          ST_IDLE: begin
            state_q <= ST_IDLE;
          end
          ST_DIV: begin
            step_q <= step_q + 4'd1;
            if (step_q == 4'(DIV_STEPS - 1)) begin
              state_q <= ST_FIX;
            end
          end
          ST_FIX: begin
            state_q <= ST_EMIT;
          end
          ST_EMIT: begin
            if (load) begin
              if (holes_left_q != 6'd0) begin
                holes_left_q <= holes_left_q - 6'd1;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
      q_q   <= {2'b00, cmd_i.left};
      r_q   <= 6'd0;
      rem_q <= 6'd0;
      neg_q <= cmd_i.value < cmd_i.left;
      if (cmd_i.value < cmd_i.left) begin
        quot_q <= cmd_i.left - cmd_i.value;
      end else begin
        quot_q <= cmd_i.value - cmd_i.left;
      end
    end
    if (state_q == ST_DIV) begin
      quot_q <= {quot_q[14:0], ge};
      rem_q  <= ge ? 6'(trial - {1'b0, cmd_q.holes}) : trial[5:0];
    end
    if (state_q == ST_FIX) begin
      // Step from quotient and remainder, with floor division for a negative step.
      if (!neg_q) begin
        dq_q <= {2'b00, quot_q};
        dr_q <= rem_q;
      end else if (rem_q == 6'd0) begin
        dq_q <= -{2'b00, quot_q};
        dr_q <= 6'd0;
      end else begin
        dq_q <= ~{2'b00, quot_q};
        dr_q <= cmd_q.holes - rem_q;
      end
    end
    if (load) begin
      out_q.new_history <= cmd_q.value;
      if (holes_left_q != 6'd0) begin
        out_q.filled_depth <= cmd_q.interp ? q_q[15:0] : 16'd0;
        out_q.last_of_run  <= 1'b0;
        out_q.row_done     <= 1'b0;
        q_q <= q_q + dq_q + {17'd0, wrap};
        r_q <= wrap ? 6'(rs - {1'b0, cmd_q.holes}) : rs[5:0];
      end else begin
        out_q.filled_depth <= cmd_q.value;
        out_q.last_of_run  <= 1'b1;
        out_q.row_done     <= cmd_q.row_end;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/depth_temporal_filter_hole_fill.sv =====
// Top level of the depth temporal filter with hole fill: configuration
// registers, front end, job queue and back end. Uses dtfhf_pkg and its modules.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in        in         in_valid_i / in_stall_o   dtfhf_pkg::in_t
//   out       out        out_valid_o / out_stall_i dtfhf_pkg::out_t
//
// The front end takes one pixel per cycle while the queue has room; a pixel's
// products are registered before its job is pushed. The back end gives one
// result per cycle when emitting, unless stalled. A run of n interpolated
// holes first goes through the serial 16-bit divide and the step fixup, then
// n+1 results follow. Reset clears the run state, the queue and the output
// valid flag; a stalled output holds its result while the queue keeps filling.
module depth_temporal_filter_hole_fill #(
  parameter int unsigned FIFO_DEPTH = dtfhf_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [8:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  input  dtfhf_pkg::in_t  in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output dtfhf_pkg::out_t out_data_o,
  input  logic            out_stall_i
);

  logic [8:0] blend_weight_q;
  logic [5:0] gap_limit_q;

  dtfhf_pkg::cfg_t       cfg;
  dtfhf_pkg::cmd_t       push_cmd, pop_cmd;
  dtfhf_pkg::fifo_stat_t fifo_stat;
  dtfhf_pkg::back_stat_t back_stat;
  logic                  push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_weight_q <= 9'(dtfhf_pkg::BLEND_RESET);
      gap_limit_q    <= 6'(dtfhf_pkg::GAP_RESET);
    end else if (cfg_we_i) begin
      case (dtfhf_pkg::cfg_idx_e'(cfg_idx_i))
        dtfhf_pkg::CFG_BLEND_WEIGHT: blend_weight_q <= cfg_wdata_i;
        dtfhf_pkg::CFG_GAP_LIMIT:    gap_limit_q    <= cfg_wdata_i[5:0];
        default: begin
          blend_weight_q <= blend_weight_q;
        end
      endcase
    end
  end

  assign cfg.weight = (blend_weight_q > 9'(dtfhf_pkg::WEIGHT_FULL)) ?
                      9'(dtfhf_pkg::WEIGHT_FULL) : blend_weight_q;
  assign cfg.limit  = (gap_limit_q > 6'(dtfhf_pkg::GAP_LIMIT_MAX)) ?
                      6'(dtfhf_pkg::GAP_LIMIT_MAX) : gap_limit_q;

  dtfhf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .fifo_i     (fifo_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dtfhf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (back_stat.take),
    .data_o (pop_cmd),
    .stat_o (fifo_stat)
  );

  dtfhf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_i      (fifo_stat),
    .cmd_i       (pop_cmd),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("job pushed into a full queue");

  // The back end only takes a job that is there.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.take |-> !fifo_stat.empty)
    else $error("job taken from an empty queue");

  // An idle back end picks up a waiting job at once.
  a_idle_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fifo_stat.empty && !back_stat.busy) |-> back_stat.take)
    else $error("idle back end left a queued job waiting");

  // A job taken by an idle back end makes it busy in the next cycle.
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.take && !back_stat.busy) |=> back_stat.busy)
    else $error("back end did not start on a taken job");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_temporal_filter_hole_fill: drives pixel requests,
// predicts blended and hole-filled results, and compares them as they stream out.
// Depends on dtfhf_pkg and the depth_temporal_filter_hole_fill RTL only.
module testbench;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_PRINTS = 50;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  dtfhf_pkg::cfg_idx_e  cfg_idx_i = dtfhf_pkg::CFG_BLEND_WEIGHT;
  logic [8:0]           cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  dtfhf_pkg::in_t       in_data_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  dtfhf_pkg::out_t      out_data_o;
  logic                 out_stall_i = 1'b0;

  // Predictor copy of the configuration and the hole filler state.
  logic [8:0]  wt_reg = 9'(dtfhf_pkg::BLEND_RESET);
  logic [5:0]  lim_reg = 6'(dtfhf_pkg::GAP_RESET);
  int unsigned left_px = 0;
  int unsigned held_zeros = 0;
  bit          run_dead = 1'b0;

  dtfhf_pkg::out_t expected_px[$];
  dtfhf_pkg::out_t want_px;

  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_go;

  depth_temporal_filter_hole_fill uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
               expected_px.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_cnt, msg);
  endtask

  // Temporal blend, then the scanline hole filler; appends what one pixel emits.
  function automatic void predict_filled(dtfhf_pkg::in_t px);
    dtfhf_pkg::out_t batch[$];
    dtfhf_pkg::out_t res;
    int unsigned     w;
    int unsigned     lim;
    int unsigned     blended;
    int unsigned     span;
    int unsigned     k;
    w = (wt_reg > dtfhf_pkg::WEIGHT_FULL) ? dtfhf_pkg::WEIGHT_FULL : int'(wt_reg);
    lim = (lim_reg > dtfhf_pkg::GAP_LIMIT_MAX) ? dtfhf_pkg::GAP_LIMIT_MAX : int'(lim_reg);
    if (px.raw_depth == 16'h0) blended = px.history_depth;
    else if (px.history_depth == 16'h0) blended = px.raw_depth;
    else blended = ((w * px.raw_depth + (dtfhf_pkg::WEIGHT_FULL - w) * px.history_depth)
                    >> 8) & 16'hFFFF;
    res = '0;
    res.new_history = 16'(blended);
    if (blended != 0) begin
      span = held_zeros;
      for (k = 0; k < span; k++) begin
        res.filled_depth = 16'((left_px * (span - k) + blended * k) / span);
        batch.push_back(res);
      end
      res.filled_depth = 16'(blended);
      batch.push_back(res);
      left_px = blended;
      held_zeros = 0;
      run_dead = 1'b0;
    end else if (left_px == 0 || run_dead) begin
      batch.push_back(res);
    end else if (held_zeros < lim && !px.row_end) begin
      held_zeros++;
    end else begin
      for (k = 0; k <= held_zeros; k++) batch.push_back(res);
      held_zeros = 0;
      if (!px.row_end) run_dead = 1'b1;
    end
    if (batch.size() > 0) begin
      res = batch.pop_back();
      res.last_of_run = 1'b1;
      res.row_done = px.row_end;
      batch.push_back(res);
    end
    if (px.row_end) begin
      left_px = 0;
      held_zeros = 0;
      run_dead = 1'b0;
    end
    foreach (batch[i]) expected_px.push_back(batch[i]);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected result, depth %0d", out_data_o.filled_depth));
      end else begin
        want_px = expected_px.pop_front();
        if (out_data_o.filled_depth !== want_px.filled_depth)
          report($sformatf("filled_depth %0d, expected %0d", out_data_o.filled_depth,
                           want_px.filled_depth));
        if (out_data_o.new_history !== want_px.new_history)
          report($sformatf("new_history %0d, expected %0d", out_data_o.new_history,
                           want_px.new_history));
        if (out_data_o.last_of_run !== want_px.last_of_run)
          report($sformatf("last_of_run %b, expected %b", out_data_o.last_of_run,
                           want_px.last_of_run));
        if (out_data_o.row_done !== want_px.row_done)
          report($sformatf("row_done %b, expected %b", out_data_o.row_done,
                           want_px.row_done));
      end
    end
  end

  // The receiver stalls at random, or solidly while a hold-off is running.
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
  end

  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  function automatic dtfhf_pkg::in_t pixel(logic [15:0] raw, logic [15:0] hist,
                                           logic row_end);
    dtfhf_pkg::in_t px;
    px.raw_depth = raw;
    px.history_depth = hist;
    px.row_end = row_end;
    return px;
  endfunction

  function automatic dtfhf_pkg::in_t rand_valid(logic row_end);
    logic [15:0] raw;
    logic [15:0] hist;
    raw = 16'($urandom);
    hist = 16'($urandom);
    case ($urandom_range(0, 5))
      0: raw = '0;
      1, 2: hist = '0;
      default: ;
    endcase
    if (raw == 16'h0 && hist == 16'h0) raw = 16'h1;
    return pixel(raw, hist, row_end);
  endfunction

  function automatic dtfhf_pkg::in_t noise_pixel();
    logic [15:0] raw;
    logic [15:0] hist;
    raw = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
    hist = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
    return pixel(raw, hist, $urandom_range(0, 3) == 0);
  endfunction

  // Offers one request after idling each cycle with the set chance, and holds it
  // until taken.
  task automatic send_pixel(dtfhf_pkg::in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    predict_filled(px);
  endtask

  // Waits for every expected result, reporting any that never arrive, then lets held pixels settle in the block.
  task automatic drain();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_px.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_px.size() != 0) begin
      report($sformatf("%0d expected results never arrived", expected_px.size()));
      expected_px.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(dtfhf_pkg::cfg_idx_e idx, logic [8:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dtfhf_pkg::CFG_BLEND_WEIGHT) wt_reg = val;
    else lim_reg = val[5:0];
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_pixel(noise_pixel());
        sent++;
      end else begin
        send_pixel(rand_valid(1'b0));
        sent++;
        // Runs right at the limit and one past it hit both filler paths.
        case ($urandom_range(0, 3))
          0: run_len = $urandom_range(1, 3);
          1: run_len = lim_reg;
          2: run_len = lim_reg + 1;
          default: run_len = $urandom_range(0, lim_reg + 3);
        endcase
        for (k = 0; k < run_len; k++) begin
          send_pixel(pixel(16'h0, 16'h0, k == run_len - 1 && $urandom_range(0, 7) == 0));
          sent++;
        end
        if ($urandom_range(0, 5) == 0) begin
          send_pixel(rand_valid(1'b1));
          sent++;
        end
      end
    end
  endtask

  task automatic test_blend_and_holes();
    send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'hFFFF, 16'h0, 1'b0));
    send_pixel(pixel(16'h0, 16'h1234, 1'b0));
    send_pixel(pixel(16'hFFFF, 16'hFFFF, 1'b0));
    send_pixel(pixel(16'h0001, 16'hFFFF, 1'b0));
    repeat (3) send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'hFFFF, 16'h0001, 1'b0));
    repeat (2) send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'h0, 16'h0, 1'b1));
    drain();
  endtask

  task automatic test_gap_limit();
    // Upper data bits are beyond the register and must be dropped.
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'h1C2);
    send_pixel(pixel(16'd100, 16'h0, 1'b0));
    repeat (4) send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'd200, 16'h0, 1'b1));
    drain();
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'h0);
    send_pixel(pixel(16'd50, 16'h0, 1'b0));
    send_pixel(pixel(16'h0, 16'h0, 1'b0));
    send_pixel(pixel(16'd60, 16'h0, 1'b1));
    drain();
  endtask

  task automatic test_weights();
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'd0);
    send_pixel(pixel(16'd40000, 16'd20000, 1'b0));
    drain();
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'd256);
    send_pixel(pixel(16'd40000, 16'd20000, 1'b0));
    drain();
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'h1FF);
    send_pixel(pixel(16'd40000, 16'd20000, 1'b1));
    drain();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 31;
    recv_idle_pct = 72;
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'($urandom_range(1, 255)));
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'd16);
    run_random(80);
    drain();
    send_idle_pct = 72;
    recv_idle_pct = 31;
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'd256);
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'd63);
    run_random(80);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'($urandom_range(0, 511)));
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'($urandom_range(1, 7)));
    run_random(80);
    drain();
  endtask

  task automatic test_backpressure();
    write_cfg(dtfhf_pkg::CFG_BLEND_WEIGHT, 9'd128);
    write_cfg(dtfhf_pkg::CFG_GAP_LIMIT, 9'd3);
    -> hold_go;
    run_random(40);
    drain();
  endtask

  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 72;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blend_and_holes();
    test_gap_limit();
    test_weights();
    test_random_traffic();
    test_backpressure();
    $display("Sent %0d pixels and checked %0d results over blend weights 0..511,", pixels_sent,
             results_seen);
    $display("gap limits 0..63, random idling on both sides and a long output hold-off.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
